// ----- sv/pfx_eval_pkg.sv -----
// Package: widths, symbol codes and status codes of the postfix evaluator.
package pfx_eval_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int FRACTION_BITS = 16;

   localparam int SYM_W  = 8;
   localparam int VAL_W  = 48;
   localparam int STAT_W = 3;

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int NUM_W  = VAL_W + FRACTION_BITS;   // dividend / quotient width
   localparam int PROD_W = 2 * VAL_W;               // full product width
   localparam int ALU_W  = VAL_W + 2;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam logic [VAL_W-1:0] VAL_MAX_MAG = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN_MAG = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
   localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 3'd0,
      STAT_UNDER = 3'd1,
      STAT_DIV0  = 3'd2,
      STAT_FULL  = 3'd3,
      STAT_SAT   = 3'd4
   } status_type;

endpackage

// ----- sv/pfx_eval_if.sv -----
// Interfaces: request and response channels of the postfix evaluator.
interface pfx_eval_req_if;
   import pfx_eval_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_expression;

   modport source (output valid, output symbol, output end_of_expression, input ready);
   modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface pfx_eval_rsp_if;
   import pfx_eval_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   status_type              status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- sv/postfix_expression_evaluator_top.sv -----
// Top level: postfix evaluator with operand stack and shared iterative ALU.
//
// Usage:
//  - req_ch carries one ASCII character per request (symbol) plus
//    end_of_expression. Digits push, * / + - pop two and push the result,
//    anything else is ignored. Values are signed Q31.16, saturating.
//  - On a request with end_of_expression set, one response goes out on
//    rsp_ch with the top of stack (0 if empty) and a status; the stack and
//    the held error are then cleared. Other requests give no response.
//  - req_ch.ready is high only in S_IDLE. Digits and ignored symbols are
//    done there; + or - pass through S_LOAD; * and / through S_LOAD, S_MAGR,
//    48 shift-add steps (S_MUL) or 64 restoring divide steps (S_DIV), S_FIN
//    and S_SIGN. All arithmetic goes through one 50-bit add/subtract unit.
//    An end-of-expression request adds S_OUT to load the response.
//  - The response is loaded in S_OUT once the last symbol is processed.
//    The response sits in an output register; if rsp_ch stalls, new
//    requests are still taken until the next response must be loaded,
//    which then waits for the held one to go.
//  - Reset (synchronous, active high) empties the stack, clears the held
//    error and drops rsp_ch.valid. The stack memory itself is not cleared;
//    only entries below the stack pointer are ever used.
module postfix_expression_evaluator_top (
   input logic             clock,
   input logic             reset,
   pfx_eval_req_if.sink    req_ch,
   pfx_eval_rsp_if.source  rsp_ch
);
   import pfx_eval_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_MAGR, S_MUL, S_DIV, S_FIN, S_SIGN, S_OUT
   } state_type;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_type;

   function automatic status_type raise_err(status_type cur, status_type code);
      return (cur == STAT_OK) ? code : cur;
   endfunction

   // control
   state_type        state_ff, state_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   status_type       err_ff, err_in;
   op_type           op_ff, op_in;
   logic             last_ff, last_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath: top of stack is cached, memory holds the entries below it
   logic [VAL_W-1:0] top_ff, top_in;
   logic [VAL_W-1:0] acc_ff, acc_in;   // product high half / remainder / magnitude
   logic [NUM_W-1:0] wrk_ff, wrk_in;   // multiplier + product low / dividend -> quotient
   logic [VAL_W-1:0] opd_ff, opd_in;   // multiplicand or divisor magnitude
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;

   // stack memory
   logic [VAL_W-1:0]  stack_mem [STACK_DEPTH];
   logic [VAL_W-1:0]  rd_ff;
   logic              mem_we;
   logic [SP_W-1:0]   sp_dec, sp_dec2;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // shared ALU
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_sub;

   // misc decode
   logic [SYM_W-1:0]  sym_off;
   logic [VAL_W-1:0]  digit_val;
   logic              as_ovf;
   logic [VAL_W-1:0]  as_val;
   logic [VAL_W-1:0]  lmag;
   logic [PROD_W-1:0] fin_full, fin_bound;
   logic              fin_sat;
   logic [VAL_W-1:0]  fin_mag;
   state_type         done_state;

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

   assign sp_dec  = sp_ff - SP_W'(1);
   assign sp_dec2 = sp_ff - SP_W'(2);
   assign wr_addr = sp_dec[ADDR_W-1:0];
   assign rd_addr = sp_dec2[ADDR_W-1:0];

   assign sym_off   = req_ch.symbol - SYM_ZERO;
   assign digit_val = VAL_W'(sym_off[3:0]) << FRACTION_BITS;

   // operand mux for the one add/subtract unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               alu_a   = {{2{rd_ff[VAL_W-1]}}, rd_ff};
               alu_b   = {{2{top_ff[VAL_W-1]}}, top_ff};
               alu_sub = (op_ff == OP_SUB);
            end else begin
               alu_b   = {2'b00, rd_ff};   // negate left operand
               alu_sub = 1'b1;
            end
         end
         S_MAGR: begin
            alu_b   = {2'b00, top_ff};
            alu_sub = 1'b1;
         end
         S_MUL: begin
            alu_a = {2'b00, acc_ff};
            alu_b = wrk_ff[0] ? {2'b00, opd_ff} : '0;
         end
         S_DIV: begin
            alu_a   = {1'b0, acc_ff, wrk_ff[NUM_W-1]};
            alu_b   = {2'b00, opd_ff};
            alu_sub = 1'b1;
         end
         S_SIGN: begin
            alu_b   = {2'b00, acc_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
         end
      endcase
   end

   assign alu_sum = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

   // add/sub saturation: result fits when the top three bits agree
   assign as_ovf = (alu_sum[ALU_W-1] != alu_sum[VAL_W-1]) ||
                   (alu_sum[ALU_W-2] != alu_sum[VAL_W-1]);
   assign as_val = !as_ovf ? alu_sum[VAL_W-1:0] :
                   (alu_sum[ALU_W-1] ? VAL_MIN_MAG : VAL_MAX_MAG);

   assign lmag = rd_ff[VAL_W-1] ? alu_sum[VAL_W-1:0] : rd_ff;

   // final magnitude clamp for multiply and divide
   assign fin_full  = (op_ff == OP_MUL) ?
                      ({acc_ff, wrk_ff[VAL_W-1:0]} >> FRACTION_BITS) :
                      PROD_W'(wrk_ff);
   assign fin_bound = neg_ff ? PROD_W'(VAL_MIN_MAG) : PROD_W'(VAL_MAX_MAG);
   assign fin_sat   = (fin_full > fin_bound);
   assign fin_mag   = fin_sat ? fin_bound[VAL_W-1:0] : fin_full[VAL_W-1:0];

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      acc_in        = acc_ff;
      wrk_in        = wrk_ff;
      opd_in        = opd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      done_state    = last_ff ? S_OUT : S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               last_in  = req_ch.end_of_expression;
               state_in = req_ch.end_of_expression ? S_OUT : S_IDLE;
               case (req_ch.symbol) inside
                  [SYM_ZERO:SYM_NINE]: begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                        err_in = raise_err(err_ff, STAT_FULL);
                     end else begin
                        mem_we = (sp_ff != '0);   // spill old top
                        sp_in  = sp_ff + SP_W'(1);
                        top_in = digit_val;
                     end
                  end
                  SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
                     case (req_ch.symbol)
                        SYM_ADD: op_in = OP_ADD;
                        SYM_SUB: op_in = OP_SUB;
                        SYM_MUL: op_in = OP_MUL;
                        default: op_in = OP_DIV;
                     endcase
                     if (sp_ff < SP_W'(2)) begin
                        err_in = raise_err(err_ff, STAT_UNDER);
                     end else begin
                        state_in = S_LOAD;   // left operand read under way
                     end
                  end
                  default: begin
                     op_in = op_ff;
                  end
               endcase
            end
         end

         S_LOAD: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               top_in   = as_val;
               sp_in    = sp_dec;
               state_in = done_state;
               if (as_ovf) begin
                  err_in = raise_err(err_ff, STAT_SAT);
               end
            end else if (op_ff == OP_DIV && top_ff == '0) begin
               top_in   = '0;
               sp_in    = sp_dec;
               err_in   = raise_err(err_ff, STAT_DIV0);
               state_in = done_state;
            end else begin
               wrk_in   = (op_ff == OP_DIV) ? (NUM_W'(lmag) << FRACTION_BITS) :
                                              NUM_W'(lmag);
               acc_in   = '0;
               neg_in   = rd_ff[VAL_W-1] ^ top_ff[VAL_W-1];
               state_in = S_MAGR;
            end
         end

         S_MAGR: begin
            opd_in   = top_ff[VAL_W-1] ? alu_sum[VAL_W-1:0] : top_ff;
            cnt_in   = '0;
            state_in = (op_ff == OP_MUL) ? S_MUL : S_DIV;
         end

         S_MUL: begin
            // shift-add, LSB of multiplier first
            acc_in             = alu_sum[VAL_W:1];
            wrk_in             = wrk_ff >> 1;
            wrk_in[VAL_W-1]    = alu_sum[0];
            cnt_in             = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VAL_W - 1)) begin
               state_in = S_FIN;
            end
         end

         S_DIV: begin
            // restoring divide, one quotient bit per step
            if (!alu_sum[ALU_W-1]) begin
               acc_in = alu_sum[VAL_W-1:0];
            end else begin
               acc_in = {acc_ff[VAL_W-2:0], wrk_ff[NUM_W-1]};
            end
            wrk_in = {wrk_ff[NUM_W-2:0], !alu_sum[ALU_W-1]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            acc_in   = fin_mag;
            state_in = S_SIGN;
            if (fin_sat) begin
               err_in = raise_err(err_ff, STAT_SAT);
            end
         end

         S_SIGN: begin
            top_in   = neg_ff ? alu_sum[VAL_W-1:0] : acc_ff;
            sp_in    = sp_dec;
            state_in = done_state;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (sp_ff != '0) ? top_ff : '0;
               if (err_ff != STAT_OK) begin
                  rsp_status_in = err_ff;
               end else if (sp_ff == '0) begin
                  rsp_status_in = STAT_UNDER;
               end else begin
                  rsp_status_in = STAT_OK;
               end
               sp_in    = '0;
               err_in   = STAT_OK;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      top_ff        <= top_in;
      acc_ff        <= acc_in;
      wrk_ff        <= wrk_in;
      opd_ff        <= opd_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_ff <= stack_mem[rd_addr];
   end

endmodule
